// File: rtl/erng_pkg.sv
// ----------------------------------------------------------------------------
// erng_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package erng_pkg;

	localparam int NUM_SENSORS = 4;
	localparam int COUNT_BITS  = 24;
	localparam int STEP_W      = $clog2(COUNT_BITS + 1);
	localparam int TRIG_W      = 4;
	localparam int SEL_W       = 2;
	localparam int CFG_W       = 16;
	localparam int IDX_W       = 2;

	localparam logic [SEL_W:0] SEL_LIMIT = (SEL_W + 1)'(NUM_SENSORS);

	// register indexes on the config port
	localparam logic [IDX_W-1:0] REG_TRIGGER = 2'd0;
	localparam logic [IDX_W-1:0] REG_TPC     = 2'd1;
	localparam logic [IDX_W-1:0] REG_HOLDOFF = 2'd2;

	localparam logic [9:0]  TRIGGER_RST = 10'd10;
	localparam logic [7:0]  TPC_RST     = 8'd58;
	localparam logic [15:0] HOLDOFF_RST = 16'd25000;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_MEAS,
		PH_HOLD
	} phase_t;

	typedef struct packed {
		logic [9:0]  trigger_ticks;
		logic [7:0]  ticks_per_cm;
		logic [15:0] holdoff_ticks;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [TRIG_W-1:0] trigger_lines;
		logic              busy;
		logic              done;
		logic [7:0]        distance;
		logic              clipped;
	} result_t;

endpackage

// File: rtl/erng_div.sv
// ----------------------------------------------------------------------------
// erng_div
// Bit-serial restoring divider, one quotient bit per cycle, with the
// quotient saturated to eight bits.
// ----------------------------------------------------------------------------
module erng_div import erng_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COUNT_BITS-1:0] dividend,
	input  logic [7:0]            divisor,
	output div_stat_t             stat,
	output logic [7:0]            distance,
	output logic                  clipped
);

	logic [COUNT_BITS-1:0] dq_q;
	logic [7:0]            rem_q;
	logic [7:0]            dvsr_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [8:0]            trial;
	logic [8:0]            diff;
	logic                  ge;

	assign trial = {rem_q, dq_q[COUNT_BITS-1]};
	assign ge    = trial >= {1'b0, dvsr_q};
	assign diff  = trial - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(COUNT_BITS);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q   <= dividend;
			rem_q  <= '0;
			// zero divisor acts as one
			dvsr_q <= (divisor == 8'd0) ? 8'd1 : divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[COUNT_BITS-2:0], ge};
			rem_q <= ge ? diff[7:0] : trial[7:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign clipped   = |dq_q[COUNT_BITS-1:8];
	assign distance  = clipped ? 8'hFF : dq_q[7:0];

endmodule

// File: rtl/erng_seq.sv
// ----------------------------------------------------------------------------
// erng_seq
// Measurement sequencer: phase, tick counter, sensor and last distance.
// ----------------------------------------------------------------------------
module erng_seq import erng_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  item_valid,
	input  logic                  item_req,
	input  logic [SEL_W-1:0]      item_sel,
	input  logic                  item_echo,
	input  logic                  out_free,
	input  div_stat_t             div_stat,
	input  logic [7:0]            div_distance,
	input  logic                  div_clipped,
	output logic                  div_start,
	output logic [COUNT_BITS-1:0] div_dividend,
	output logic                  commit,
	output result_t               res
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	phase_t                phase_q, phase_nx;
	logic [COUNT_BITS-1:0] count_q, count_nx, count_inc;
	logic [SEL_W-1:0]      sensor_q, sensor_nx;
	logic [7:0]            dist_q, dist_nx;
	logic                  clip_q, clip_nx;
	logic                  done_nx;
	logic                  div_pend_q;
	logic                  finish;
	logic                  ready;

	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

	// a falling echo needs the divider before the word can complete
	assign finish       = item_valid && !item_req && phase_q == PH_MEAS && !item_echo;
	assign div_start    = finish && !div_pend_q;
	assign div_dividend = count_q;
	assign ready        = item_valid && (!finish || (div_pend_q && div_stat.done));
	assign commit       = ready && out_free;

	always_comb begin
		phase_nx  = phase_q;
		count_nx  = count_q;
		sensor_nx = sensor_q;
		dist_nx   = dist_q;
		clip_nx   = clip_q;
		done_nx   = 1'b0;
		if (item_req) begin
			if (phase_q == PH_IDLE && {1'b0, item_sel} < SEL_LIMIT) begin
				sensor_nx = item_sel;
				count_nx  = '0;
				phase_nx  = PH_TRIG;
			end
		end else begin
			case (phase_q)
				PH_TRIG: begin
					count_nx = count_inc;
					if (count_inc >= COUNT_BITS'(cfg.trigger_ticks)) begin
						count_nx = '0;
						phase_nx = PH_WAIT;
					end
				end
				PH_WAIT: begin
					if (item_echo) begin
						count_nx = COUNT_BITS'(1);
						phase_nx = PH_MEAS;
					end
				end
				PH_MEAS: begin
					if (item_echo) begin
						count_nx = count_inc;
					end else begin
						dist_nx  = div_distance;
						clip_nx  = div_clipped;
						count_nx = '0;
						done_nx  = 1'b1;
						phase_nx = (cfg.holdoff_ticks != 16'd0) ? PH_HOLD : PH_IDLE;
					end
				end
				PH_HOLD: begin
					count_nx = count_inc;
					if (count_inc >= COUNT_BITS'(cfg.holdoff_ticks)) begin
						count_nx = '0;
						phase_nx = PH_IDLE;
					end
				end
				default: begin
					phase_nx = PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.trigger_lines = '0;
		if (phase_nx == PH_TRIG) begin
			res.trigger_lines = TRIG_W'(1) << sensor_nx;
		end
		res.busy     = phase_nx != PH_IDLE;
		res.done     = done_nx;
		res.distance = dist_nx;
		res.clipped  = clip_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= '0;
			sensor_q   <= '0;
			dist_q     <= '0;
			clip_q     <= 1'b0;
			div_pend_q <= 1'b0;
		end else begin
			if (div_start) begin
				div_pend_q <= 1'b1;
			end else if (commit) begin
				div_pend_q <= 1'b0;
			end
			if (commit) begin
				phase_q  <= phase_nx;
				count_q  <= count_nx;
				sensor_q <= sensor_nx;
				dist_q   <= dist_nx;
				clip_q   <= clip_nx;
			end
		end
	end

endmodule

// File: rtl/ultrasonic_echo_ranger_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Ranging control for up to four echo sensors: trigger pulse, echo timing,
// serial distance division and holdoff, one result word per input word.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  in       | in_valid / in_stall   | req_type, sensor_sel, echo_level
//  out      | out_valid / out_stall | trigger_lines, busy_res, done_res,
//           |                       | distance_cm, clipped
//  cfg      | cfg_we                | cfg_index, cfg_data
//
// One word is in flight at a time. The word on which the echo falls runs
// the serial divider, one quotient bit per cycle, before its result is
// written to the output register; other words complete without it.
// Reset puts the config registers at 10 / 58 / 25000 and the phase at idle.
// The input is stalled while a word is in flight; a stalled result is held
// in the output register and the next word waits behind it.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core import erng_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [SEL_W-1:0]  sensor_sel,
	input  logic              echo_level,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [TRIG_W-1:0] trigger_lines,
	output logic              busy_res,
	output logic              done_res,
	output logic [7:0]        distance_cm,
	output logic              clipped
);

	cfg_t                  cfg_q;
	logic                  item_q;
	logic                  req_q;
	logic [SEL_W-1:0]      sel_q;
	logic                  echo_q;
	logic                  out_valid_q;
	result_t               out_q;
	result_t               res;
	logic                  out_free;
	logic                  commit;
	logic                  accept;
	logic                  div_start;
	logic [COUNT_BITS-1:0] div_dividend;
	div_stat_t             div_stat;
	logic [7:0]            div_distance;
	logic                  div_clipped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks <= TRIGGER_RST;
			cfg_q.ticks_per_cm  <= TPC_RST;
			cfg_q.holdoff_ticks <= HOLDOFF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIGGER: cfg_q.trigger_ticks <= cfg_data[9:0];
				REG_TPC:     cfg_q.ticks_per_cm  <= cfg_data[7:0];
				REG_HOLDOFF: cfg_q.holdoff_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = item_q && !commit;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				item_q <= 1'b1;
			end else if (commit) begin
				item_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			sel_q  <= sensor_sel;
			echo_q <= echo_level;
		end
		if (commit) begin
			out_q <= res;
		end
	end

	erng_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (item_q),
		.item_req     (req_q),
		.item_sel     (sel_q),
		.item_echo    (echo_q),
		.out_free     (out_free),
		.div_stat     (div_stat),
		.div_distance (div_distance),
		.div_clipped  (div_clipped),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.commit       (commit),
		.res          (res)
	);

	erng_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cfg_q.ticks_per_cm),
		.stat     (div_stat),
		.distance (div_distance),
		.clipped  (div_clipped)
	);

	assign out_valid     = out_valid_q;
	assign trigger_lines = out_q.trigger_lines;
	assign busy_res      = out_q.busy;
	assign done_res      = out_q.done;
	assign distance_cm   = out_q.distance;
	assign clipped       = out_q.clipped;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while running");

	a_commit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !div_stat.busy)
		else $error("word completed while divider running");

	a_trig_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0(out_q.trigger_lines))
		else $error("more than one trigger line");

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.trigger_lines != '0) |-> out_q.busy)
		else $error("trigger without busy");

	a_commit_item: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && !item_q || (out_valid_q && item_q))
		else $error("completed word not presented");

endmodule
